// ----- hdl/bfsb_pkg.sv -----
// Shared types, constants and helper functions of the bit-map find-set-bit block.
// Used by bfsb_ctrl and bitmap_find_set_bit_core; no other dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bfsb_pkg;

    // Map geometry
    localparam int WORD_BITS = 64;
    localparam int MAX_BITS  = 1024;
    localparam int NWORDS    = (MAX_BITS + WORD_BITS - 1) / WORD_BITS;
    localparam int WIDX_W    = $clog2(NWORDS);
    localparam int BIT_W     = $clog2(WORD_BITS);
    localparam int IDX_W     = 10;
    localparam int CAP_W     = 11;
    localparam int CNT_W     = WIDX_W + 1;

    // Stream widths (fields packed from bit 0, padded to whole bytes)
    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 16;
    localparam int CMD_W      = 3;

    typedef enum logic [CMD_W-1:0] {
        CMD_SET        = 3'd0,
        CMD_CLEAR      = 3'd1,
        CMD_FIND_FIRST = 3'd2,
        CMD_FIND_NEXT  = 3'd3,
        CMD_FILL       = 3'd4
    } cmd_t;

    // Memory port request from the sequencer
    typedef struct packed {
        logic                 rd_en;
        logic [WIDX_W-1:0]    rd_addr;
        logic                 wr_en;
        logic [WIDX_W-1:0]    wr_addr;
        logic [WORD_BITS-1:0] wr_data;
    } mem_req_t;

    // One result item
    typedef struct packed {
        logic             index_error;
        logic [IDX_W-1:0] found_index;
        logic             found;
    } res_t;

    // Bits of word w that lie below the effective capacity
    function automatic logic [WORD_BITS-1:0] usable_mask(input logic [CAP_W-1:0] eff_cap,
                                                          input logic [WIDX_W-1:0] w);
        logic [CAP_W-1:0]     lo;
        logic [CAP_W-1:0]     diff;
        logic [WORD_BITS-1:0] m;
        lo   = CAP_W'(w) << BIT_W;
        diff = '0;
        if (eff_cap <= lo) begin
            m = '0;
        end
        else begin
            diff = eff_cap - lo;
            if (diff >= CAP_W'(WORD_BITS))
                m = '1;
            else
                m = (WORD_BITS'(1) << diff[BIT_W-1:0]) - WORD_BITS'(1);
        end
        return m;
    endfunction

    // Priority encoder: position of the lowest set bit
    function automatic logic [BIT_W-1:0] lowest_bit(input logic [WORD_BITS-1:0] v);
        logic [BIT_W-1:0] p;
        p = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (v[i])
                p = BIT_W'(i);
        end
        return p;
    endfunction

endpackage

`default_nettype wire

// ----- hdl/bfsb_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// Standalone; no package dependency.
`timescale 1ns / 1ps
`default_nettype none

module bfsb_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
            rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

// ----- hdl/bfsb_ctrl.sv -----
// Command sequencer: read-modify-write of map words, pipelined word scan, fill sweep.
// Depends on bfsb_pkg; drives the map RAM through a mem_req_t request.
`timescale 1ns / 1ps
`default_nettype none

module bfsb_ctrl (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [bfsb_pkg::CMD_W-1:0]    cmd,
    input  wire logic [bfsb_pkg::IDX_W-1:0]    bit_index,
    input  wire logic                          fill_value,
    input  wire logic [bfsb_pkg::CAP_W-1:0]    eff_cap,
    output logic                               res_valid,
    input  wire logic                          res_ready,
    output bfsb_pkg::res_t                     res,
    output bfsb_pkg::mem_req_t                 mem,
    input  wire logic [bfsb_pkg::WORD_BITS-1:0] rd_data
);
    import bfsb_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RMW,
        ST_SCAN,
        ST_FILL,
        ST_DONE
    } state_t;

    state_t               state_reg, state_next;
    res_t                 res_reg, res_next;
    logic [NWORDS-1:0]    valid_reg, valid_next;
    logic [WIDX_W-1:0]    resume_reg, resume_next;
    logic [WIDX_W-1:0]    w_reg, w_next;
    logic [CNT_W-1:0]     k_reg, k_next;
    logic [CNT_W-1:0]     n_reg, n_next;
    logic                 move_reg, move_next;
    logic                 fill_reg, fill_next;
    logic                 setop_reg, setop_next;
    logic [IDX_W-1:0]     bit_reg, bit_next;
    logic                 p_valid_reg, p_valid_next;
    logic                 p_last_reg, p_last_next;
    logic                 p_vbit_reg, p_vbit_next;
    logic [WIDX_W-1:0]    p_w_reg, p_w_next;

    cmd_t                 cmd_c;
    logic                 accept;
    logic [CNT_W-1:0]     n_words;
    logic [WORD_BITS-1:0] cur_word;
    logic [WORD_BITS-1:0] bit_mask;
    logic [WORD_BITS-1:0] scan_bits;
    logic [WIDX_W-1:0]    w_inc;

    assign cmd_c    = cmd_t'(cmd);
    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;
    assign res_valid = (state_reg == ST_DONE);
    assign res       = res_reg;

    // Words in use: ceil(capacity / word size)
    assign n_words = CNT_W'((12'(eff_cap) + 12'(WORD_BITS - 1)) >> BIT_W);

    // Word returned by the RAM; a never-written word reads as zero
    assign cur_word  = p_vbit_reg ? rd_data : '0;
    assign bit_mask  = WORD_BITS'(1) << bit_reg[BIT_W-1:0];
    assign scan_bits = cur_word & usable_mask(eff_cap, p_w_reg);
    assign w_inc     = ((CNT_W'(w_reg) + CNT_W'(1)) == n_reg) ? '0 : w_reg + WIDX_W'(1);

    // Next-state logic
    always_comb
    begin
        state_next   = state_reg;
        res_next     = res_reg;
        valid_next   = valid_reg;
        resume_next  = resume_reg;
        w_next       = w_reg;
        k_next       = k_reg;
        n_next       = n_reg;
        move_next    = move_reg;
        fill_next    = fill_reg;
        setop_next   = setop_reg;
        bit_next     = bit_reg;
        p_valid_next = 1'b0;
        p_last_next  = p_last_reg;
        p_vbit_next  = p_vbit_reg;
        p_w_next     = p_w_reg;
        mem          = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    res_next = '0;
                    unique case (cmd_c) inside
                        CMD_SET, CMD_CLEAR:
                        begin
                            if (CAP_W'(bit_index) >= eff_cap)
                            begin
                                res_next.index_error = 1'b1;
                                state_next = ST_DONE;
                            end
                            else
                            begin
                                mem.rd_en   = 1'b1;
                                mem.rd_addr = bit_index[IDX_W-1:BIT_W];
                                p_vbit_next = valid_reg[bit_index[IDX_W-1:BIT_W]];
                                bit_next    = bit_index;
                                setop_next  = (cmd_c == CMD_SET);
                                state_next  = ST_RMW;
                            end
                        end
                        CMD_FIND_FIRST, CMD_FIND_NEXT:
                        begin
                            if (n_words == '0)
                            begin
                                state_next = ST_DONE;
                            end
                            else
                            begin
                                move_next = (cmd_c == CMD_FIND_NEXT);
                                if (cmd_c == CMD_FIND_NEXT && CNT_W'(resume_reg) < n_words)
                                    w_next = resume_reg;
                                else
                                    w_next = '0;
                                k_next     = '0;
                                n_next     = n_words;
                                state_next = ST_SCAN;
                            end
                        end
                        CMD_FILL:
                        begin
                            fill_next  = fill_value;
                            w_next     = '0;
                            state_next = ST_FILL;
                        end
                        default:
                        begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end
            ST_RMW:
            begin
                mem.wr_en   = 1'b1;
                mem.wr_addr = bit_reg[IDX_W-1:BIT_W];
                mem.wr_data = setop_reg ? (cur_word | bit_mask) : (cur_word & ~bit_mask);
                valid_next[bit_reg[IDX_W-1:BIT_W]] = 1'b1;
                state_next  = ST_DONE;
            end
            ST_SCAN:
            begin
                // Issue one word read per cycle
                if (k_reg < n_reg)
                begin
                    mem.rd_en    = 1'b1;
                    mem.rd_addr  = w_reg;
                    p_valid_next = 1'b1;
                    p_w_next     = w_reg;
                    p_vbit_next  = valid_reg[w_reg];
                    p_last_next  = (k_reg == n_reg - CNT_W'(1));
                    k_next       = k_reg + CNT_W'(1);
                    w_next       = w_inc;
                end
                // Check the word read in the previous cycle
                if (p_valid_reg)
                begin
                    if (scan_bits != '0)
                    begin
                        res_next.found       = 1'b1;
                        res_next.found_index = {p_w_reg, lowest_bit(scan_bits)};
                        if (move_reg)
                            resume_next = p_w_reg;
                        p_valid_next = 1'b0;
                        state_next   = ST_DONE;
                    end
                    else if (p_last_reg)
                    begin
                        p_valid_next = 1'b0;
                        state_next   = ST_DONE;
                    end
                end
            end
            ST_FILL:
            begin
                mem.wr_en   = 1'b1;
                mem.wr_addr = w_reg;
                mem.wr_data = fill_reg ? usable_mask(eff_cap, w_reg) : '0;
                valid_next[w_reg] = 1'b1;
                w_next      = w_reg + WIDX_W'(1);
                if (w_reg == WIDX_W'(NWORDS - 1))
                begin
                    resume_next = '0;
                    state_next  = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (res_ready)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            valid_reg   <= '0;
            resume_reg  <= '0;
            p_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            valid_reg   <= valid_next;
            resume_reg  <= resume_next;
            p_valid_reg <= p_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        res_reg    <= res_next;
        w_reg      <= w_next;
        k_reg      <= k_next;
        n_reg      <= n_next;
        move_reg   <= move_next;
        fill_reg   <= fill_next;
        setop_reg  <= setop_next;
        bit_reg    <= bit_next;
        p_last_reg <= p_last_next;
        p_vbit_reg <= p_vbit_next;
        p_w_reg    <= p_w_next;
    end

    // Checks
    a_found_no_err: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.found |-> !res.index_error)
        else $error("found and index_error both set");

    a_notfound_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res.found |-> res.found_index == '0)
        else $error("found_index nonzero without a hit");

    a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(mem.rd_en && mem.wr_en))
        else $error("map read and write in the same cycle");

    a_ready_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !res_valid)
        else $error("new request taken while a result is pending");

    a_scan_hold: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SCAN && $past(state_reg) == ST_SCAN |-> $stable(n_reg))
        else $error("word count changed during a scan");

endmodule

`default_nettype wire

// ----- hdl/bitmap_find_set_bit_core.sv -----
// Bit-map allocator with find-first and next-fit find-set-bit commands.
// Command stream in (s_*), result stream out (m_*), capacity register write (cfg_*).
// Set/clear: the map word is read, then modified and written back in ST_RMW; the result
// then waits in ST_DONE, and an index out of range goes straight to ST_DONE.
// Find: the scan reads one map word per cycle from the single RAM read port and
// stops early on a hit; a miss reads every word in use.
// Fill: one word per cycle through the RAM write port, 16 writes.
// Every request yields exactly one result.  The result sits in an output register;
// while the receiver stalls the sequencer may finish the next request and holds it
// until the register frees up, then takes no new request until it is delivered.
// Reset: map reads as all zero (per-word valid bits), pointer 0, capacity 1024.
// No clearing pass is needed, so the block is ready right after reset.
// cfg writes are always accepted and must be made only while the block is idle.
// Depends on bfsb_pkg, bfsb_ctrl and bfsb_ram.
`timescale 1ns / 1ps
`default_nettype none

module bitmap_find_set_bit_core (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // bits: [2:0] cmd, [12:3] bit_index, [13] fill_value, [15:14] zero
    input  wire logic [bfsb_pkg::IN_DATA_W-1:0]    s_tdata,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // bits: [0] found, [10:1] found_index, [11] index_error, [15:12] zero
    output logic      [bfsb_pkg::OUT_DATA_W-1:0]   m_tdata,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    input  wire logic [bfsb_pkg::CAP_W-1:0]        cfg_data,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready
);
    import bfsb_pkg::*;

    logic [CAP_W-1:0]      cap_reg;
    logic [CAP_W-1:0]      eff_cap;
    logic                  m_tvalid_reg;
    logic [OUT_DATA_W-1:0] m_tdata_reg;
    logic                  res_valid;
    logic                  res_ready;
    res_t                  res;
    mem_req_t              mem;
    logic [WORD_BITS-1:0]  rd_data;

    // Capacity register, saturated at the map size
    assign cfg_ready = 1'b1;
    assign eff_cap   = (cap_reg > CAP_W'(MAX_BITS)) ? CAP_W'(MAX_BITS) : cap_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cap_reg <= CAP_W'(MAX_BITS);
        else if (cfg_valid && cfg_ready)
            cap_reg <= cfg_data;
    end

    // Map storage
    bfsb_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (NWORDS)
    ) u_ram (
        .clk     (clk),
        .wr_en   (mem.wr_en),
        .wr_addr (mem.wr_addr),
        .wr_data (mem.wr_data),
        .rd_en   (mem.rd_en),
        .rd_addr (mem.rd_addr),
        .rd_data (rd_data)
    );

    // Command sequencer
    bfsb_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .cmd        (s_tdata[CMD_W-1:0]),
        .bit_index  (s_tdata[CMD_W+IDX_W-1:CMD_W]),
        .fill_value (s_tdata[CMD_W+IDX_W]),
        .eff_cap    (eff_cap),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res),
        .mem        (mem),
        .rd_data    (rd_data)
    );

    // Output register
    assign res_ready = !m_tvalid_reg || m_tready;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tvalid_reg <= 1'b0;
        else if (res_ready)
            m_tvalid_reg <= res_valid;
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
            m_tdata_reg <= OUT_DATA_W'({res.index_error, res.found_index, res.found});
    end

endmodule

`default_nettype wire
